@@ rtl/mpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and constants for the max priority queue
// Entry layout, operation codes and width constants used by the cell chain
// and the top level.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int VALUE_W     = 32;
  localparam int PRIO_W      = 16;
  localparam int MODE_W      = 2;
  localparam int OCC_W       = 7;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic enq;  // insert new item into the sorted chain
    logic deq;  // shift the chain toward the head
  } cell_cmd_t;

  // True when a is served before b: larger priority, then larger value.
  function automatic logic entry_greater(entry_t a, entry_t b);
    entry_greater = (a.prio > b.prio) || ((a.prio == b.prio) && (a.value > b.value));
  endfunction

endpackage

@@ rtl/mpq_cell.sv @@
// ----------------------------------------------------------------------------
// mpq_cell: one slot of the sorted priority chain
// Holds one entry. On insert it keeps, takes the new item or takes its left
// neighbor; on removal it takes its right neighbor.
// ----------------------------------------------------------------------------
module mpq_cell (
  input  logic              clk,
  input  mpq_pkg::cell_cmd_t cmd,
  input  mpq_pkg::entry_t   new_item,
  input  logic              occupied,
  input  mpq_pkg::entry_t   left_entry,
  input  logic              left_gt,
  input  mpq_pkg::entry_t   right_entry,
  output mpq_pkg::entry_t   entry,
  output logic              gt
);
  import mpq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // new item belongs at or ahead of this slot
  assign gt    = !occupied || entry_greater(new_item, entry_r);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (cmd.enq && gt && left_gt) begin
      entry_nxt = left_entry;
    end else if (cmd.enq && gt) begin
      entry_nxt = new_item;
    end else if (cmd.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ rtl/max_priority_queue.sv @@
// ----------------------------------------------------------------------------
// max_priority_queue: bounded max priority queue on a sorted cell chain
//
// Usage: drive in_mode, in_item_value and in_item_priority and pulse start;
// the item is taken at any edge where start is high and busy is low. busy
// never rises: an operation can be taken every clock cycle.
// Modes: enqueue, dequeue highest, peek highest; mode 3 is a no-op.
// Entries sit in QUEUE_DEPTH cells kept sorted, highest at cell 0 (larger
// priority first, larger value on a tie). An enqueue compares the item in
// every cell at once and the chain opens a gap where it belongs; a dequeue
// shifts the whole chain one cell toward the head. Besides the new item,
// each cell talks only to its neighbors; cost is one 48-bit compare per cell.
// The result is registered at the accepting edge and shown for exactly
// one cycle, marked by out_strobe. The block takes one item per cycle.
// The receiver cannot stall; a result not taken in its cycle is lost.
// Every item gives exactly one result with occupancy and full flag; an
// enqueue on a full queue is dropped and flagged by out_dropped.
// Reset (rst_n low, synchronous) empties the queue and clears out_strobe;
// cell contents are not cleared, slots beyond the count are never shown.
// ----------------------------------------------------------------------------
module max_priority_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [mpq_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [mpq_pkg::VALUE_W-1:0] in_item_value,
  input  logic signed [mpq_pkg::PRIO_W-1:0]  in_item_priority,
  output logic                              out_strobe,
  output logic                              out_valid,
  output logic signed [mpq_pkg::VALUE_W-1:0] out_value,
  output logic signed [mpq_pkg::PRIO_W-1:0]  out_priority,
  output logic                              out_dropped,
  output logic [mpq_pkg::OCC_W-1:0]         out_occupancy,
  output logic                              out_is_full
);
  import mpq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             strobe_r;
  logic             valid_r, valid_nxt;
  entry_t           head_r, head_nxt;
  logic             dropped_r, dropped_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             full_r, full_nxt;

  entry_t             new_item;
  entry_t             cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_gt;
  logic [QUEUE_DEPTH-1:0] cell_occ;
  cell_cmd_t          cmd;
  logic               accept;
  logic               full, empty;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);

  assign new_item.value = in_item_value;
  assign new_item.prio  = in_item_priority;

  assign cmd.enq = accept && (in_mode == MODE_ENQ) && !full;
  assign cmd.deq = accept && (in_mode == MODE_DEQ) && !empty;

  // slot i holds a live entry when it sits below the count
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_occ[i] = (CNT_W'(i) < count_r);
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_g;
    if (i == 0) begin : g_head
      assign left_e = new_item;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_g = cell_gt[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = new_item;
    end else begin : g_body
      assign right_e = cell_entry[i+1];
    end
    mpq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .new_item   (new_item),
      .occupied   (cell_occ[i]),
      .left_entry (left_e),
      .left_gt    (left_g),
      .right_entry(right_e),
      .entry      (cell_entry[i]),
      .gt         (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // result fields: head entry from before this item's update, occupancy after
  always_comb begin
    valid_nxt   = ((in_mode == MODE_DEQ) || (in_mode == MODE_PEEK)) && !empty;
    head_nxt    = valid_nxt ? cell_entry[0] : '0;
    dropped_nxt = (in_mode == MODE_ENQ) && full;
    occ_wide    = {{OCC_W{1'b0}}, count_nxt};
    occ_nxt     = occ_wide[OCC_W-1:0];
    full_nxt    = (count_nxt == CNT_W'(QUEUE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      valid_r   <= valid_nxt;
      head_r    <= head_nxt;
      dropped_r <= dropped_nxt;
      occ_r     <= occ_nxt;
      full_r    <= full_nxt;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_valid     = valid_r;
  assign out_value     = head_r.value;
  assign out_priority  = head_r.prio;
  assign out_dropped   = dropped_r;
  assign out_occupancy = occ_r;
  assign out_is_full   = full_r;

endmodule

@@ bench/tb_max_priority_queue.sv @@
// ----------------------------------------------------------------------------
// tb_max_priority_queue: self-checking bench for the max priority queue
// Drives enqueue, dequeue, peek and no-op items through the start/busy
// handshake, predicts every result with a queue model of its own and checks
// each strobed result field by field, across phases of sender idling.
// ----------------------------------------------------------------------------
module tb_max_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import mpq_pkg::*;

  // Mode 3 has no package name; the block treats it as a no-op.
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [PRIO_W-1:0]  PRIO_MIN  = {1'b1, {(PRIO_W-1){1'b0}}};
  localparam logic signed [PRIO_W-1:0]  PRIO_MAX  = {1'b0, {(PRIO_W-1){1'b1}}};

  localparam int RESET_CYCLES = 8;
  localparam int TAIL_CYCLES  = 8;       // margin after the last awaited result arrives
  localparam int RUN_LIMIT    = 200000;  // watchdog limit for the whole run
  localparam int MAX_SHOWN    = 10;
  localparam int PHASE_ITEMS  = 375;

  // Sender idle percentage per phase. The third phase is the stalled
  // receiver setting; results cannot be held off, so it runs flat out.
  localparam int PHASE_IDLE [4] = '{0, 85, 0, 34};

  typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED, BURST_TIES} burst_kind_t;

  typedef struct {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    int                        idle_pct;
    bit                        wait_drain;  // hold off until nothing is awaited
  } queue_op_t;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    logic                      dropped;
    logic [OCC_W-1:0]          occ;
    logic                      full;
  } reply_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [MODE_W-1:0]         in_mode = '0;
  logic signed [VALUE_W-1:0] in_item_value = '0;
  logic signed [PRIO_W-1:0]  in_item_priority = '0;
  logic                      out_strobe;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic signed [PRIO_W-1:0]  out_priority;
  logic                      out_dropped;
  logic [OCC_W-1:0]          out_occupancy;
  logic                      out_is_full;

  queue_op_t op_backlog[$];        // items not yet handed to the block
  reply_t    awaited_replies[$];   // predicted results, oldest first
  logic signed [VALUE_W-1:0] held_values[$];  // model contents, arrival order
  logic signed [PRIO_W-1:0]  held_prios[$];

  logic item_taken = 1'b0;  // start was accepted at the last rising edge
  int   cycle_count = 0;
  int   mismatches = 0;

  max_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_strobe       (out_strobe),
    .out_valid        (out_valid),
    .out_value        (out_value),
    .out_priority     (out_priority),
    .out_dropped      (out_dropped),
    .out_occupancy    (out_occupancy),
    .out_is_full      (out_is_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Queue model: highest priority wins, larger value breaks a tie, the first
  // entry is the starting candidate so an all-minimum queue still serves.
  // Dequeue removes the winner and keeps the rest in arrival order.
  // --------------------------------------------------------------------------
  function automatic reply_t apply_queue_op(logic [MODE_W-1:0] mode,
                                            logic signed [VALUE_W-1:0] value,
                                            logic signed [PRIO_W-1:0] prio);
    reply_t r;
    int     best;
    int     i;
    r = '0;
    if (mode == MODE_ENQ) begin
      if (held_values.size() >= QUEUE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        held_values.push_back(value);
        held_prios.push_back(prio);
      end
    end else if ((mode == MODE_DEQ || mode == MODE_PEEK) && held_values.size() > 0) begin
      best = 0;
      for (i = 1; i < held_values.size(); i++) begin
        if (held_prios[i] > held_prios[best] ||
            (held_prios[i] == held_prios[best] && held_values[i] > held_values[best]))
          best = i;
      end
      r.valid = 1'b1;
      r.value = held_values[best];
      r.prio  = held_prios[best];
      if (mode == MODE_DEQ) begin
        held_values.delete(best);
        held_prios.delete(best);
      end
    end
    r.occ  = OCC_W'(held_values.size());
    r.full = (held_values.size() == QUEUE_DEPTH);
    return r;
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("cycle %0d: %s mismatch, expected %0d, got %0d",
                 cycle_count, field, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [MODE_W-1:0] pick_mode(burst_kind_t kind);
    int roll;
    int enq_pct;
    int deq_pct;
    roll = $urandom_range(99);
    case (kind)
      BURST_FILL: begin
        enq_pct = 85;
        deq_pct = 8;
      end
      BURST_DRAIN: begin
        enq_pct = 15;
        deq_pct = 70;
      end
      default: begin
        enq_pct = 45;
        deq_pct = 35;
      end
    endcase
    if (roll < enq_pct) return MODE_ENQ;
    if (roll < enq_pct + deq_pct) return MODE_DEQ;
    if (roll < 97) return MODE_PEEK;
    return MODE_NOP;
  endfunction

  // Narrow picks crowd values around zero so ties are common.
  function automatic logic signed [VALUE_W-1:0] pick_value(bit narrow);
    int roll;
    roll = $urandom_range(9);
    if (narrow || roll < 3) return $signed($urandom_range(4)) - 2;
    if (roll == 3) return VALUE_MIN;
    if (roll == 4) return VALUE_MAX;
    return $urandom;
  endfunction

  function automatic logic signed [PRIO_W-1:0] pick_prio(bit narrow);
    int roll;
    roll = $urandom_range(9);
    if (narrow || roll < 3) return PRIO_W'($signed($urandom_range(4)) - 2);
    if (roll == 3) return PRIO_MIN;
    if (roll == 4) return PRIO_MAX;
    return PRIO_W'($urandom_range(65535));
  endfunction

  task automatic add_op(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] value,
                        logic signed [PRIO_W-1:0] prio, int idle_pct, bit wait_drain);
    op_backlog.push_back('{mode, value, prio, idle_pct, wait_drain});
  endtask

  task automatic add_burst(burst_kind_t kind, int len, int idle_pct, bit wait_drain);
    bit narrow;
    int n;
    narrow = (kind == BURST_TIES);
    for (n = 0; n < len; n++)
      add_op(pick_mode(kind), pick_value(narrow), pick_prio(narrow), idle_pct,
             wait_drain && n == 0);
  endtask

  // --------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A new item is presented once
  // the previous one was taken; start stays high across back-to-back items.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    queue_op_t op;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (op_backlog.size() == 0) begin
        start <= 1'b0;
      end else if (op_backlog[0].wait_drain && awaited_replies.size() != 0) begin
        start <= 1'b0;
      end else if ($urandom_range(99) < op_backlog[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        op = op_backlog.pop_front();
        in_mode          <= op.mode;
        in_item_value    <= op.value;
        in_item_priority <= op.prio;
        start            <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples on the rising edge. A strobed result is checked before
  // the item accepted at the same edge is predicted, keeping order intact.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    reply_t want;
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= start && !busy;
      if (out_strobe) begin
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("cycle %0d: result arrived with none awaited", cycle_count);
        end else begin
          want = awaited_replies.pop_front();
          check_field("valid", want.valid, out_valid);
          check_field("value", want.value, out_value);
          check_field("priority", want.prio, out_priority);
          check_field("dropped", want.dropped, out_dropped);
          check_field("occupancy", want.occ, out_occupancy);
          check_field("is_full", want.full, out_is_full);
        end
      end
      if (start && !busy)
        awaited_replies.push_back(apply_queue_op(in_mode, in_item_value, in_item_priority));
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("max_priority_queue regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          ph;
    int          queued;
    int          len;
    burst_kind_t kind;

    // Directed: empty queue on every non-enqueue mode, value extremes at
    // the minimum priority (first entry must still be the candidate), a
    // tie settled by value, a fully equal pair, and a no-op on a busy queue.
    add_op(MODE_PEEK, VALUE_MAX, PRIO_MAX, 0, 1'b0);
    add_op(MODE_DEQ,  VALUE_MIN, PRIO_MIN, 0, 1'b0);
    add_op(MODE_NOP,  VALUE_MAX, PRIO_MAX, 0, 1'b0);
    add_op(MODE_ENQ,  VALUE_MIN, PRIO_MIN, 0, 1'b0);
    add_op(MODE_ENQ,  VALUE_MAX, PRIO_MIN, 0, 1'b0);
    add_op(MODE_ENQ,  0,         PRIO_MIN, 0, 1'b0);
    add_op(MODE_PEEK, 0,         0,        0, 1'b0);
    add_op(MODE_DEQ,  0,         0,        0, 1'b0);
    add_op(MODE_DEQ,  0,         0,        0, 1'b0);
    add_op(MODE_DEQ,  0,         0,        0, 1'b0);
    add_op(MODE_DEQ,  0,         0,        0, 1'b0);
    add_op(MODE_ENQ,  5,         PRIO_MAX, 0, 1'b0);
    add_op(MODE_ENQ,  7,         PRIO_MAX, 0, 1'b0);
    add_op(MODE_ENQ,  7,         PRIO_MAX, 0, 1'b0);
    add_op(MODE_ENQ,  -1,        PRIO_W'(-1), 0, 1'b0);
    add_op(MODE_NOP,  VALUE_MIN, PRIO_MIN, 0, 1'b0);
    add_op(MODE_PEEK, 0,         0,        0, 1'b0);
    add_op(MODE_DEQ,  0,         0,        0, 1'b0);
    add_op(MODE_DEQ,  0,         0,        0, 1'b0);
    add_op(MODE_DEQ,  0,         0,        0, 1'b0);
    add_op(MODE_DEQ,  0,         0,        0, 1'b0);
    add_op(MODE_DEQ,  0,         0,        0, 1'b0);

    // Random phases. Each opens by waiting for the block to go quiet, then
    // fills well past the depth (drops while full), runs a dequeue-heavy drain,
    // then mixes bursts of every kind.
    for (ph = 0; ph < 4; ph++) begin
      add_burst(BURST_FILL, 100, PHASE_IDLE[ph], 1'b1);
      add_burst(BURST_DRAIN, 100, PHASE_IDLE[ph], 1'b0);
      queued = 200;
      while (queued < PHASE_ITEMS) begin
        kind = burst_kind_t'($urandom_range(3));
        len  = $urandom_range(20, 80);
        add_burst(kind, len, PHASE_IDLE[ph], 1'b0);
        queued += len;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (op_backlog.size() != 0 || start || awaited_replies.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("max_priority_queue regression: pass");
    end else begin
      $display("max_priority_queue regression: fail");
    end
    $finish;
  end

endmodule
